>>> hw/rtl/fnvcd_pkg.sv
// ----------------------------------------------------------------------------
// fnvcd_pkg
// Shared types, constants and the FNV-1a byte mixing function for the
// chained digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package fnvcd_pkg;

    localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
    // The prime is 2^40 + 0x1b3, so the product is a shift plus a narrow multiply.
    localparam int          FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;
    localparam int          WORD_BYTES      = 8;

    localparam logic [1:0] SIZE_64  = 2'd0;
    localparam logic [1:0] SIZE_128 = 2'd1;

    localparam logic [1:0] IDX_WORD0 = 2'd0;
    localparam logic [1:0] IDX_WORD1 = 2'd1;
    localparam logic [1:0] IDX_WORD3 = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_BYTE,
        OP_END,
        OP_BYTE_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } queue_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MIX
    } back_state_t;

    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        logic [63:0] low;
        x   = h ^ {56'd0, b};
        low = x * {55'd0, FNV_PRIME_LOW};
        return (x << FNV_PRIME_SHIFT) + low;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/fnvcd_front.sv
// ----------------------------------------------------------------------------
// fnvcd_front
// Accepts input items, classifies them into byte, end and byte-with-end
// operations, and queues them for the hashing back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvcd_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      byte_valid,
    output logic                     byte_stall,
    input  fnvcd_pkg::in_item_t      byte_item,
    output logic                     q_valid,
    output fnvcd_pkg::queue_entry_t  q_entry,
    input  wire                      q_pop
);
    import fnvcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg,  count_next;
    logic                    accept;
    logic                    push;
    logic                    pop;
    queue_entry_t            new_entry;

    assign byte_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept     = byte_valid && !byte_stall;
    // An item with neither a byte nor an end mark has no effect and is dropped.
    assign push       = accept && (byte_item.byte_present || byte_item.is_last);
    assign q_valid    = (count_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_entry    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.data_byte = byte_item.data_byte;
        if (byte_item.byte_present && byte_item.is_last)
        begin
            new_entry.op = OP_BYTE_END;
        end
        else if (byte_item.is_last)
        begin
            new_entry.op = OP_END;
        end
        else
        begin
            new_entry.op = OP_BYTE;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fnvcd_back.sv
// ----------------------------------------------------------------------------
// fnvcd_back
// Executes queued operations: mixes message bytes into the running hash and,
// at an end mark, produces the chained digest words one byte round at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module fnvcd_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_write,
    input  wire [1:0]                cfg_data,
    input  wire                      q_valid,
    input  fnvcd_pkg::queue_entry_t  q_entry,
    output logic                     q_pop,
    output logic                     digest_valid,
    input  wire                      digest_stall,
    output fnvcd_pkg::out_item_t     digest_item
);
    import fnvcd_pkg::*;

    back_state_t  state_reg, state_next;
    logic [63:0]  hash_reg,  hash_next;
    logic [63:0]  word_reg,  word_next;
    logic [63:0]  acc_reg,   acc_next;
    logic [63:0]  src_reg,   src_next;
    logic [2:0]   cnt_reg,   cnt_next;
    logic [1:0]   idx_reg,   idx_next;
    logic [1:0]   size_reg;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_item_reg,  out_item_next;
    logic         out_free;
    logic [1:0]   last_idx;
    logic [63:0]  byte_mix;
    logic [63:0]  round_mix;

    assign out_free     = !out_valid_reg || !digest_stall;
    assign digest_valid = out_valid_reg;
    assign digest_item  = out_item_reg;
    assign byte_mix     = fnv_mix(hash_reg, q_entry.data_byte);
    assign round_mix    = fnv_mix(acc_reg, src_reg[7:0]);

    // The unused size code behaves as the 256-bit mode.
    always_comb
    begin
        unique case (size_reg)
            SIZE_64:  last_idx = IDX_WORD0;
            SIZE_128: last_idx = IDX_WORD1;
            default:  last_idx = IDX_WORD3;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        word_next      = word_reg;
        acc_next       = acc_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && digest_stall;
        q_pop          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.op)
                        OP_BYTE:
                        begin
                            hash_next = byte_mix;
                        end
                        OP_BYTE_END:
                        begin
                            word_next  = byte_mix;
                            hash_next  = FNV_BASIS;
                            idx_next   = IDX_WORD0;
                            state_next = ST_EMIT;
                        end
                        OP_END:
                        begin
                            word_next  = hash_reg;
                            hash_next  = FNV_BASIS;
                            idx_next   = IDX_WORD0;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            hash_next = hash_reg;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.digest_word = word_reg;
                    out_item_next.word_index  = idx_reg;
                    out_item_next.last_word   = (idx_reg == last_idx);
                    if (idx_reg == last_idx)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Word 2 continues from the hash state that produced word 1,
                        // which equals word 1 itself; the other words start fresh.
                        src_next   = word_reg;
                        acc_next   = (idx_reg == IDX_WORD1) ? word_reg : FNV_BASIS;
                        cnt_next   = '0;
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                acc_next = round_mix;
                src_next = {8'd0, src_reg[63:8]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'(WORD_BYTES - 1))
                begin
                    word_next  = round_mix;
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= FNV_BASIS;
            size_reg      <= SIZE_64;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            if (cfg_write)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        acc_reg      <= acc_next;
        src_reg      <= src_next;
        out_item_reg <= out_item_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/fnv1a_chained_digest.sv
// Message bytes are taken one per cycle while the queue has room; each is mixed into the hash
// register once the back end pops it. An end item loads word 0 into the word register as it
// leaves the queue; each word goes on to the output register, and each further word is first
// built by byte rounds over the 8 bytes of the previous one. An end item holds the back end
// until its last digest word is in the output register, plus any output stall.
// Reset clears the queue, sets the hash to the offset basis and the size to 64-bit.
// ----------------------------------------------------------------------------
// fnv1a_chained_digest
// 64-bit FNV-1a stream hasher with a chained 64, 128 or 256-bit digest.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a_chained_digest #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   cfg_write,
    input  wire [1:0]             cfg_data,
    input  wire                   byte_valid,
    output logic                  byte_stall,
    input  fnvcd_pkg::in_item_t   byte_item,
    output logic                  digest_valid,
    input  wire                   digest_stall,
    output fnvcd_pkg::out_item_t  digest_item
);
    import fnvcd_pkg::*;

    logic         q_valid;
    logic         q_pop;
    queue_entry_t q_entry;

    fnvcd_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    fnvcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained FNV-1a digest block. A driver and a
// monitor run on opposite clock edges with random gaps and stalls, and every
// digest word is checked against a local hash predictor.
// ----------------------------------------------------------------------------

module testbench;

    import fnvcd_pkg::*;

    localparam logic [63:0] FNV_PRIME64    = 64'h0000_0100_0000_01b3;
    localparam logic [1:0]  SIZE_256       = 2'd2;
    localparam logic [1:0]  SIZE_SATURATE  = 2'd3;
    localparam int          RANDOM_ITEMS   = 250;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          DRAIN_CYCLES   = 40;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          MAX_WAIT       = 18;
    localparam int          SHOWN_ERRORS   = 10;

    typedef struct {
        bit         is_cfg;
        logic [1:0] size;
        in_item_t   item;
    } pending_op_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      cfg_write    = 1'b0;
    logic [1:0] cfg_data    = SIZE_64;
    logic      byte_valid   = 1'b0;
    logic      byte_stall;
    in_item_t  byte_item    = '0;
    logic      digest_valid;
    logic      digest_stall = 1'b0;
    out_item_t digest_item;

    pending_op_t pending_ops[$];
    out_item_t   expected_words[$];

    // Predictor state.
    logic [63:0] message_hash = FNV_BASIS;
    logic [1:0]  size_reg     = SIZE_64;

    logic byte_taken     = 1'b0;
    logic digest_taken   = 1'b0;
    logic digest_waiting = 1'b0;
    bit   send_burst     = 1'b0;
    bit   recv_burst     = 1'b0;
    int   send_gap       = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    int       mismatch_count = 0;
    int       items_taken    = 0;
    int       digests_done   = 0;
    int       words_checked  = 0;
    logic [3:0] sizes_seen   = 4'b0001;

    fnv1a_chained_digest dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME64;
    endfunction

    // Bytes of the word go in least significant first.
    function automatic logic [63:0] fnv_absorb_word(input logic [63:0] h,
                                                    input logic [63:0] w);
        logic [63:0] acc;
        acc = h;
        for (int i = 0; i < 8; i++)
        begin
            acc = fnv_absorb(acc, w[8*i +: 8]);
        end
        return acc;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
        begin
            $display("%0t: %s", $time, text);
        end
    endtask

    task automatic predict_digest(input in_item_t it);
        logic [63:0] chain [4];
        int          words;
        out_item_t   word;
        if (it.byte_present)
        begin
            message_hash = fnv_absorb(message_hash, it.data_byte);
        end
        if (it.is_last)
        begin
            chain[0] = message_hash;
            chain[1] = fnv_absorb_word(FNV_BASIS, chain[0]);
            chain[2] = fnv_absorb_word(fnv_absorb_word(FNV_BASIS, chain[0]), chain[1]);
            chain[3] = fnv_absorb_word(FNV_BASIS, chain[2]);
            message_hash = FNV_BASIS;
            case (size_reg)
                SIZE_64:  words = 1;
                SIZE_128: words = 2;
                default:  words = 4;
            endcase
            for (int i = 0; i < words; i++)
            begin
                word.digest_word = chain[i];
                word.word_index  = 2'(i);
                word.last_word   = (i == words - 1);
                expected_words.push_back(word);
            end
            digests_done++;
        end
    endtask

    task automatic push_item(input logic [7:0] data, input logic present, input logic last);
        pending_op_t op;
        op.is_cfg            = 1'b0;
        op.size              = SIZE_64;
        op.item.data_byte    = data;
        op.item.byte_present = present;
        op.item.is_last      = last;
        pending_ops.push_back(op);
    endtask

    task automatic push_size(input logic [1:0] size);
        pending_op_t op;
        op.is_cfg = 1'b1;
        op.size   = size;
        op.item   = '0;
        pending_ops.push_back(op);
    endtask

    // Monitor: checks digest words and feeds accepted items to the predictor.
    always @(posedge clk)
    begin : check_and_predict
        out_item_t want;
        byte_taken     <= rst_n && byte_valid && !byte_stall;
        digest_taken   <= rst_n && digest_valid && !digest_stall;
        digest_waiting <= digest_valid;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                size_reg = cfg_data;
                sizes_seen[cfg_data] = 1'b1;
            end
            if (digest_valid && !digest_stall)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest word %h index %0d",
                                              digest_item.digest_word,
                                              digest_item.word_index));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (digest_item.digest_word !== want.digest_word)
                        report_mismatch($sformatf("digest_word expected %h got %h",
                                                  want.digest_word, digest_item.digest_word));
                    if (digest_item.word_index !== want.word_index)
                        report_mismatch($sformatf("word_index expected %0d got %0d",
                                                  want.word_index, digest_item.word_index));
                    if (digest_item.last_word !== want.last_word)
                        report_mismatch($sformatf("last_word expected %0d got %0d",
                                                  want.last_word, digest_item.last_word));
                end
            end
            if (byte_valid && !byte_stall)
            begin
                items_taken++;
                predict_digest(byte_item);
            end
        end
    end

    // Driver: sends queued items with random gaps; size writes wait for an idle block.
    always @(negedge clk)
    begin : drive_inputs
        logic       nxt_valid;
        in_item_t   nxt_item;
        logic       nxt_write;
        logic [1:0] nxt_size;
        pending_op_t op;
        nxt_valid = byte_valid && !byte_taken;
        nxt_item  = byte_item;
        nxt_write = 1'b0;
        nxt_size  = cfg_data;
        if (byte_valid || digest_valid || expected_words.size() != 0)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (rst_n && !nxt_valid)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_ops.size() != 0)
            begin
                if (pending_ops[0].is_cfg)
                begin
                    if (quiet_cycles >= SETTLE_CYCLES)
                    begin
                        op           = pending_ops.pop_front();
                        nxt_write    = 1'b1;
                        nxt_size     = op.size;
                        quiet_cycles = 0;
                    end
                end
                else
                begin
                    op        = pending_ops.pop_front();
                    nxt_valid = 1'b1;
                    nxt_item  = op.item;
                    if ($urandom_range(0, 23) == 0)
                        send_burst = !send_burst;
                    send_gap = draw_wait(send_burst);
                end
            end
        end
        byte_valid <= nxt_valid;
        byte_item  <= nxt_item;
        cfg_write  <= nxt_write;
        cfg_data   <= nxt_size;
    end

    // The stall count for the next word only runs down while a word is waiting.
    always @(negedge clk)
    begin : drive_stall
        if (digest_taken)
        begin
            if ($urandom_range(0, 23) == 0)
                recv_burst = !recv_burst;
            hold_left = draw_wait(recv_burst);
        end
        else if (digest_waiting && hold_left > 0)
        begin
            hold_left--;
        end
        digest_stall <= (hold_left > 0);
    end

    initial
    begin : stimulus
        int       msg_len;
        int       queued;
        int       leftover;
        // Reset size first: empty message, zero byte, byte on the end item,
        // then an item with neither byte nor end.
        push_item(8'h5a, 1'b0, 1'b1);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'ha5, 1'b0, 1'b0);
        push_item(8'h3c, 1'b0, 1'b1);
        push_size(SIZE_256);
        push_item(8'h61, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'hff, 1'b1, 1'b0);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hc3, 1'b0, 1'b1);
        push_size(SIZE_128);
        push_item(8'h00, 1'b1, 1'b0);
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'hff, 1'b1, 1'b1);
        push_item(8'h00, 1'b0, 1'b1);
        // The unused size code behaves as the widest digest.
        push_size(SIZE_SATURATE);
        push_item(8'h00, 1'b0, 1'b1);
        push_item(8'h80, 1'b1, 1'b1);
        push_size(SIZE_64);
        push_item(8'h01, 1'b1, 1'b1);

        // Random messages, mostly short, with the odd long one and idle items mixed in.
        queued = 0;
        while (queued < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                push_size(2'($urandom_range(0, 3)));
            msg_len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 6);
            for (int k = 0; k < msg_len; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                queued++;
            end
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            queued++;
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        do @(negedge clk);
        while (pending_ops.size() != 0 || byte_valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        leftover = expected_words.size();
        for (int i = 0; i < leftover; i++)
        begin
            report_mismatch($sformatf("digest word %h never arrived",
                                      expected_words[i].digest_word));
        end

        $display("Run covered %0d input items and %0d digests (%0d words checked).",
                 items_taken, digests_done, words_checked);
        $display("Size codes used (bit per code): %b; %0d mismatches counted.",
                 sizes_seen, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : watchdog
        int idle_run;
        idle_run = 0;
        @(posedge rst_n);
        while (idle_run < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_valid && !byte_stall) || (digest_valid && !digest_stall) || cfg_write)
                idle_run = 0;
            else
                idle_run++;
        end
        $display("Timeout: %0d cycles without any transfer.", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fnvcd_pkg.sv
hw/rtl/fnvcd_front.sv
hw/rtl/fnvcd_back.sv
hw/rtl/fnv1a_chained_digest.sv
tb/testbench.sv
